// ----- design/shs_pkg.sv -----
// Shared types, constants and round functions for the SHA-256 stream hasher.
package shs_pkg;

  localparam int unsigned CMD_DEPTH    = 4;
  localparam int unsigned DIGEST_WORDS = 8;
  localparam int unsigned SCHED_WORDS  = 16;
  localparam logic [7:0]  PAD_MARK     = 8'h80;
  localparam logic [5:0]  LEN_POS      = 6'd56;
  localparam logic [5:0]  LAST_POS     = 6'd63;
  localparam logic [5:0]  LAST_ROUND   = 6'd63;
  localparam logic [2:0]  LAST_WORD    = 3'd7;
  localparam logic [1:0]  WORD_END     = 2'd3;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // One queued request for the core: a byte to absorb and/or a finish marker.
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       fin;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } core_state_t;

  localparam word_t INIT_HASH [DIGEST_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t rotr(word_t x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_sig0(word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sig1(word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t sml_sig0(word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t sml_sig1(word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t round_k(logic [5:0] r);
    word_t k;
    unique case (r)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

// ----- design/shs_front.sv -----
// Front end: accepts input requests, drops empty ones and queues the rest for the core.
module shs_front
  import shs_pkg::*;
#(
  parameter int unsigned Depth = CMD_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  in_item_t in_item,
  output logic     full,
  input  logic     q_pop,
  output logic     q_empty,
  output cmd_t     q_head
);

  localparam int unsigned PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  cmd_t          mem_r [Depth];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          keep, wr_en, rd_en;

  assign full    = (cnt_r == CW'(Depth));
  assign q_empty = (cnt_r == '0);
  assign q_head  = mem_r[rd_ptr_r];

  // A request with neither flag set changes nothing: accept it and drop it.
  assign keep  = in_item.byte_present | in_item.end_of_message;
  assign wr_en = push & ~full & keep;
  assign rd_en = q_pop & ~q_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= '{data:     in_item.data_byte,
                            has_byte: in_item.byte_present,
                            fin:      in_item.end_of_message};
    end
  end

endmodule

// ----- design/shs_core.sv -----
// Back end: byte packing, padding, 64-round compression and digest output.
module shs_core
  import shs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  cmd_t      q_head,
  output logic      q_pop,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  core_state_t state_r, state_nxt;

  word_t       h_r   [DIGEST_WORDS];
  word_t       v_r   [DIGEST_WORDS];
  word_t       dig_r [DIGEST_WORDS];
  word_t       w_r   [SCHED_WORDS];
  logic [23:0] word_r;
  logic [63:0] bit_cnt_r;
  logic [63:0] len_r;
  logic [5:0]  rnd_r;
  logic [2:0]  idx_r;
  logic        pad_r, mark_r, extra_r, final_r;

  logic [5:0]  pos;
  logic        take, byte_we, blk_full, len_byte, out_take;
  logic [7:0]  byte_val;
  word_t       t1, t2, ch, maj, w_new;
  word_t       v_new [DIGEST_WORDS];
  word_t       h_sum [DIGEST_WORDS];

  assign pos = bit_cnt_r[8:3];

  // Control decode
  always_comb begin
    take     = 1'b0;
    byte_we  = 1'b0;
    byte_val = '0;
    len_byte = 1'b0;
    out_take = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        take     = ~q_empty;
        byte_we  = ~q_empty & q_head.has_byte;
        byte_val = q_head.data;
      end
      ST_PAD: begin
        byte_we  = 1'b1;
        len_byte = ~mark_r & ~extra_r & (pos >= LEN_POS);
        if (mark_r) begin
          byte_val = PAD_MARK;
        end else if (len_byte) begin
          byte_val = len_r[63:56];
        end
      end
      ST_EMIT: begin
        out_take = pop;
      end
      default: ;
    endcase
    blk_full = byte_we & (pos == LAST_POS);
  end

  assign q_pop = take;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (take) begin
          if (blk_full) begin
            state_nxt = ST_ROUND;
          end else if (q_head.fin) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (blk_full) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (rnd_r == LAST_ROUND) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (final_r) begin
          state_nxt = ST_EMIT;
        end else if (pad_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (pop && idx_r == LAST_WORD) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // One compression round and one schedule word
  always_comb begin
    ch    = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    maj   = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t1    = v_r[7] + big_sig1(v_r[4]) + ch + round_k(rnd_r) + w_r[0];
    t2    = big_sig0(v_r[0]) + maj;
    w_new = w_r[0] + sml_sig0(w_r[1]) + w_r[9] + sml_sig1(w_r[14]);
    v_new[0] = t1 + t2;
    v_new[1] = v_r[0];
    v_new[2] = v_r[1];
    v_new[3] = v_r[2];
    v_new[4] = v_r[3] + t1;
    v_new[5] = v_r[4];
    v_new[6] = v_r[5];
    v_new[7] = v_r[6];
    for (int i = 0; i < DIGEST_WORDS; i++) begin
      h_sum[i] = h_r[i] + v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      h_r       <= INIT_HASH;
      bit_cnt_r <= '0;
      rnd_r     <= '0;
      idx_r     <= '0;
      pad_r     <= 1'b0;
      mark_r    <= 1'b0;
      extra_r   <= 1'b0;
      final_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (byte_we) begin
        bit_cnt_r <= bit_cnt_r + 64'd8;
      end
      if (take) begin
        pad_r   <= q_head.fin;
        mark_r  <= q_head.fin;
        extra_r <= 1'b0;
        final_r <= 1'b0;
      end
      if (state_r == ST_PAD) begin
        mark_r <= 1'b0;
        if (blk_full) begin
          extra_r <= 1'b0;
        end else if (mark_r) begin
          // mark landed in the length field: finish this block with zeros
          extra_r <= (pos >= LEN_POS);
        end
        if (len_byte && blk_full) begin
          final_r <= 1'b1;
        end
      end
      if (state_r == ST_ROUND) begin
        rnd_r <= rnd_r + 1'b1;
      end
      if (state_r == ST_FOLD) begin
        if (final_r) begin
          h_r       <= INIT_HASH;
          bit_cnt_r <= '0;
          pad_r     <= 1'b0;
          final_r   <= 1'b0;
          idx_r     <= '0;
        end else begin
          h_r <= h_sum;
        end
      end
      if (out_take) begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_we) begin
      word_r <= {word_r[15:0], byte_val};
      if (pos[1:0] == WORD_END) begin
        for (int i = 0; i < SCHED_WORDS - 1; i++) begin
          w_r[i] <= w_r[i+1];
        end
        w_r[SCHED_WORDS-1] <= {word_r, byte_val};
      end
    end
    if (blk_full) begin
      v_r <= h_r;
    end
    if (state_r == ST_ROUND) begin
      v_r <= v_new;
      for (int i = 0; i < SCHED_WORDS - 1; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[SCHED_WORDS-1] <= w_new;
    end
    if (state_r == ST_PAD) begin
      if (mark_r) begin
        len_r <= bit_cnt_r;
      end else if (len_byte) begin
        len_r <= {len_r[55:0], 8'h00};
      end
    end
    if (state_r == ST_FOLD && final_r) begin
      dig_r <= h_sum;
    end
    if (out_take) begin
      for (int i = 0; i < DIGEST_WORDS - 1; i++) begin
        dig_r[i] <= dig_r[i+1];
      end
    end
  end

  assign empty    = (state_r != ST_EMIT);
  assign out_item = '{digest_word: dig_r[0],
                      word_index:  idx_r,
                      last_word:   (idx_r == LAST_WORD)};

endmodule

// ----- design/sha256_stream_hasher.sv -----
// Top level of the SHA-256 stream hasher: request queue in front of the hashing core.
//
// Usage
//   Input channel: present one request on in_item and raise push; it is taken at a
//   rising edge with push high and full low. A request carries an optional message
//   byte (byte_present) and an end flag (end_of_message). A request with neither
//   flag set is taken and dropped.
//   Result channel: while empty is low, out_item holds the oldest digest word; raise
//   pop to take it. Each finished message yields eight words, index 0 first, with
//   last_word set on the eighth.
//   Timing: the core absorbs queued bytes in order; every 64th byte adds 64
//   compression rounds and a fold on the single shared round unit, and no byte is
//   taken until these are done. On end of message the core writes the padding one
//   byte a cycle, compresses once or twice and then offers the digest.
//   The front queue keeps taking requests while the core hashes or waits for the
//   receiver; when the receiver stalls, the core holds the digest and the queue
//   fills until full is raised.
//   Reset (synchronous, rst_n low): empty the queue, restore the initial chaining
//   words and clear the bit count.
module sha256_stream_hasher
  import shs_pkg::*;
#(
  parameter int unsigned QueueDepth = CMD_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  in_item_t  in_item,
  output logic      full,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  cmd_t q_head;
  logic q_empty;
  logic q_pop;

  // Front: classify requests and queue the ones that do work
  shs_front #(
    .Depth(QueueDepth)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .in_item (in_item),
    .full    (full),
    .q_pop   (q_pop),
    .q_empty (q_empty),
    .q_head  (q_head)
  );

  // Back: absorb, pad, compress and hand out the digest
  shs_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule

// ----- design/shs_checker.sv -----
// Port-level checks for the SHA-256 stream hasher, bound to the top level.
module shs_checker
  import shs_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      full,
  input logic      empty,
  input logic      pop,
  input out_item_t out_item
);

  logic out_fire;
  assign out_fire = pop & ~empty;

  a_empty_after_reset: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> (empty && !full))
    else $error("outputs not idle after reset");

  a_digest_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !out_item.last_word) |=> !empty)
    else $error("digest stopped before its last word");

  a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !out_item.last_word) |=>
      (out_item.word_index == 3'($past(out_item.word_index) + 3'd1)))
    else $error("digest word index did not advance by one");

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_item.last_word) |=> empty)
    else $error("result offered straight after a final word");

  a_last_at_seven: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_item.last_word == (out_item.word_index == LAST_WORD)))
    else $error("last word flag out of step with word index");

endmodule

bind sha256_stream_hasher shs_checker u_shs_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_item (out_item)
);
